// ===== rtl/i2cras_pkg.sv =====
// ============================================================================
// I2C register access sequencer - shared definitions
// Payload structs, configuration, store request and command/status codes.
// ============================================================================
package i2cras_pkg;

  localparam int STORE_DEPTH      = 256;
  localparam int STORE_AW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int START_WAIT_LIMIT = 1000;

  localparam logic [8:0] STORE_DEPTH_W      = 9'(STORE_DEPTH);
  localparam logic [9:0] START_WAIT_LIMIT_W = 10'(START_WAIT_LIMIT);

  // commands
  localparam logic [1:0] CMD_POLL  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  // strobe codes
  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [1:0] SCLR_NONE   = 2'd0;
  localparam logic [1:0] SCLR_ALL    = 2'd1;
  localparam logic [1:0] SCLR_ERRORS = 2'd2;

  localparam logic [1:0] DREAD_NONE    = 2'd0;
  localparam logic [1:0] DREAD_STORE   = 2'd1;
  localparam logic [1:0] DREAD_DISCARD = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TRANSFER_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RECOVERY_TIMEOUT = 2'd1;

  // controller status / control bits
  localparam int S1_SB_BIT    = 0;
  localparam int S1_BTF_BIT   = 2;
  localparam int S1_STOPF_BIT = 4;
  localparam int S1_RXNE_BIT  = 6;
  localparam int S1_TXE_BIT   = 7;
  localparam int S1_ARLO_BIT  = 9;
  localparam logic [15:0] S1_ERRORS = 16'h5F00;
  localparam int S2_MSL_BIT   = 0;
  localparam int S2_BUSY_BIT  = 1;
  localparam int C_STOP_BIT   = 9;
  localparam int C_ACK_BIT    = 10;

  // result codes, upper field of the error word
  localparam logic [8:0] CODE_BUSY     = 9'd16;
  localparam logic [8:0] CODE_NO_START = 9'd17;
  localparam logic [8:0] CODE_TIMEOUT  = 9'd18;
  localparam int         ERR_RESET_BIT = 24;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_DEVADDR   = 8'b0000_0010,
    PH_RESTART   = 8'b0000_0100,
    PH_READ      = 8'b0000_1000,
    PH_WRITE     = 8'b0001_0000,
    PH_STOP      = 8'b0010_0000,
    PH_ERROR     = 8'b0100_0000,
    PH_STARTWAIT = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  target_address;
    logic [7:0]  register_address;
    logic [7:0]  byte_count;
    logic [7:0]  load_index;
    logic [7:0]  load_value;
    logic [15:0] status_one;
    logic [15:0] status_two;
    logic [15:0] control_now;
    logic [31:0] time_now;
  } in_t;

  typedef struct packed {
    logic        data_write_valid;
    logic [7:0]  data_write_value;
    logic        request_start;
    logic        request_stop;
    logic [1:0]  ack_control;
    logic [1:0]  status_clear;
    logic        bus_reset;
    logic [1:0]  data_read;
    logic [7:0]  read_index;
    logic        done_res;
    logic [24:0] result_code;
  } out_t;

  typedef struct packed {
    logic [15:0] transfer_timeout;
    logic [15:0] recovery_timeout;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  // numeric phase as reported in the error word
  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] c;
    case (ph)
      PH_DEVADDR:   c = 3'd1;
      PH_RESTART:   c = 3'd2;
      PH_READ:      c = 3'd3;
      PH_WRITE:     c = 3'd4;
      PH_STOP:      c = 3'd5;
      PH_ERROR:     c = 3'd6;
      PH_STARTWAIT: c = 3'd7;
      default:      c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/i2c_register_access_sequencer.sv =====
// ============================================================================
// I2C register access sequencer - top level
// Input register, transaction engine, write store and result register.
// ============================================================================
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------
//  in      | in  | in_valid_i / in_ready_o | in_data_i  (in_t)
//  out     | out | out_valid_o/ out_ready_i| out_data_o (out_t)
//  cfg     | in  | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
//  One transaction per clock sustained while out accepts; out_valid_o rises once
//  the accepted item has passed the input register, then the result register.
//  The store read port is prefetched at the next byte position, so it never
//  stalls the engine.
//  Back-pressure on out stalls the engine; in stays ready while the result
//  register drains in the same cycle.
//  Reset clears the phase and context; no clearing pass is needed.
//
module i2c_register_access_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2cras_pkg::in_t      in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cras_pkg::out_t     out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_wdata_i
);

  logic                   in_valid_q;
  i2cras_pkg::in_t        in_q;
  logic                   out_valid_q;
  i2cras_pkg::out_t       out_q;
  i2cras_pkg::cfg_t       cfg_q;
  i2cras_pkg::out_t       result;
  i2cras_pkg::store_req_t store_req;
  logic [7:0]             store_rdata;
  logic                   step_en;

  assign step_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step_en) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transfer_timeout <= 16'd20;
      cfg_q.recovery_timeout <= 16'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2cras_pkg::CFG_TRANSFER_TIMEOUT: cfg_q.transfer_timeout <= cfg_wdata_i;
        i2cras_pkg::CFG_RECOVERY_TIMEOUT: cfg_q.recovery_timeout <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  i2cras_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  i2cras_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .item_i        (in_q),
    .cfg_i         (cfg_q),
    .store_rdata_i (store_rdata),
    .store_req_o   (store_req),
    .result_o      (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/i2cras_store.sv =====
// ============================================================================
// I2C register access sequencer - write byte store
// One write port, one registered read port, new data forwarded on a collision.
// ============================================================================
module i2cras_store (
  input  logic                     clk_i,
  input  i2cras_pkg::store_req_t   req_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [i2cras_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_q <= req_i.wdata;
    end else begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/i2cras_core.sv =====
// ============================================================================
// I2C register access sequencer - transaction engine
// Phase state and per-transaction context; one item decoded per step.
// ============================================================================
module i2cras_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_en_i,
  input  i2cras_pkg::in_t          item_i,
  input  i2cras_pkg::cfg_t         cfg_i,
  input  logic [7:0]               store_rdata_i,
  output i2cras_pkg::store_req_t   store_req_o,
  output i2cras_pkg::out_t         result_o
);

  i2cras_pkg::phase_e phase_q, phase_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  rlen_q, rlen_d;
  logic [7:0]  wlen_q, wlen_d;
  logic [7:0]  pos_q, pos_d;
  logic [24:0] err_q, err_d;
  logic [31:0] tstart_q, tstart_d;
  logic [1:0]  drain_q, drain_d;
  logic [9:0]  wait_q, wait_d;

  i2cras_pkg::out_t res;
  logic        store_we;
  logic        busy, master, finished, pos_in_store, xfer_late, recov_late;
  logic [15:0] sr1, cr;
  logic [31:0] elapsed;

  assign sr1          = item_i.status_one;
  assign cr           = item_i.control_now;
  assign busy         = item_i.status_two[i2cras_pkg::S2_BUSY_BIT];
  assign master       = item_i.status_two[i2cras_pkg::S2_MSL_BIT];
  assign elapsed      = item_i.time_now - tstart_q;
  assign xfer_late    = elapsed > {16'b0, cfg_i.transfer_timeout};
  assign recov_late   = elapsed > {16'b0, cfg_i.recovery_timeout};
  assign pos_in_store = {1'b0, pos_q} < i2cras_pkg::STORE_DEPTH_W;

  always_comb begin
    phase_d  = phase_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    rlen_d   = rlen_q;
    wlen_d   = wlen_q;
    pos_d    = pos_q;
    err_d    = err_q;
    tstart_d = tstart_q;
    drain_d  = drain_q;
    wait_d   = wait_q;
    res      = '0;
    store_we = 1'b0;
    finished = 1'b0;

    case (item_i.command)
      i2cras_pkg::CMD_LOAD: begin
        store_we = {1'b0, item_i.load_index} < i2cras_pkg::STORE_DEPTH_W;
      end
      i2cras_pkg::CMD_READ, i2cras_pkg::CMD_WRITE: begin
        if (phase_q == i2cras_pkg::PH_IDLE) begin
          dev_d  = item_i.target_address;
          reg_d  = item_i.register_address;
          rlen_d = (item_i.command == i2cras_pkg::CMD_READ)  ? item_i.byte_count : 8'd0;
          wlen_d = (item_i.command == i2cras_pkg::CMD_WRITE) ? item_i.byte_count : 8'd0;
          pos_d  = 8'd0;
          err_d  = '0;
          if (busy) begin
            err_d    = {i2cras_pkg::CODE_BUSY, sr1};
            phase_d  = i2cras_pkg::PH_ERROR;
            drain_d  = 2'd0;
            tstart_d = item_i.time_now;
          end else begin
            res.status_clear  = i2cras_pkg::SCLR_ERRORS;
            res.ack_control   = i2cras_pkg::ACK_ENABLE;
            res.request_start = 1'b1;
            wait_d            = 10'd0;
            phase_d           = i2cras_pkg::PH_STARTWAIT;
          end
        end
      end
      default: begin
        case (phase_q)
          i2cras_pkg::PH_IDLE: begin
          end
          i2cras_pkg::PH_STARTWAIT: begin
            if (sr1[i2cras_pkg::S1_SB_BIT]) begin
              res.data_write_valid = 1'b1;
              res.data_write_value = {dev_q[7:1], 1'b0};
              tstart_d             = item_i.time_now;
              phase_d              = i2cras_pkg::PH_DEVADDR;
            end else begin
              wait_d = wait_q + 10'd1;
              if (wait_d >= i2cras_pkg::START_WAIT_LIMIT_W) begin
                err_d    = {i2cras_pkg::CODE_NO_START, sr1};
                phase_d  = i2cras_pkg::PH_ERROR;
                drain_d  = 2'd0;
                tstart_d = item_i.time_now;
              end
            end
          end
          i2cras_pkg::PH_ERROR: begin
            if (recov_late) begin
              err_d                                = err_q;
              err_d[i2cras_pkg::ERR_RESET_BIT]     = 1'b1;
              res.bus_reset                        = 1'b1;
              tstart_d                             = item_i.time_now;
            end else if (cr[i2cras_pkg::C_ACK_BIT]) begin
              res.ack_control = i2cras_pkg::ACK_DISABLE;
              drain_d = sr1[i2cras_pkg::S1_BTF_BIT] ? 2'd2 : 2'd1;
            end else if (busy && master && !sr1[i2cras_pkg::S1_STOPF_BIT] &&
                         !cr[i2cras_pkg::C_STOP_BIT] && (drain_q == 2'd0)) begin
              res.request_stop = 1'b1;
            end else if (sr1[i2cras_pkg::S1_RXNE_BIT]) begin
              res.data_read = i2cras_pkg::DREAD_DISCARD;
              if (drain_q != 2'd0) begin
                drain_d = drain_q - 2'd1;
              end
            end else if (!busy) begin
              res.status_clear = i2cras_pkg::SCLR_ALL;
              res.done_res     = 1'b1;
              res.result_code  = err_q;
              phase_d          = i2cras_pkg::PH_IDLE;
              dev_d            = 8'd0;
              reg_d            = 8'd0;
              rlen_d           = 8'd0;
              wlen_d           = 8'd0;
              pos_d            = 8'd0;
              err_d            = '0;
            end
          end
          default: begin
            if ((phase_q != i2cras_pkg::PH_STOP) && ((sr1 & i2cras_pkg::S1_ERRORS) != 16'd0))
            begin
              err_d = {6'd0, i2cras_pkg::phase_code(phase_q), sr1 & i2cras_pkg::S1_ERRORS};
              res.status_clear = i2cras_pkg::SCLR_ALL;
              if (!sr1[i2cras_pkg::S1_ARLO_BIT] && busy && master) begin
                res.request_stop = 1'b1;
              end
              phase_d  = i2cras_pkg::PH_STOP;
              finished = 1'b1;
            end else begin
              case (phase_q)
                i2cras_pkg::PH_STOP: begin
                  if (!busy) begin
                    res.done_res    = 1'b1;
                    res.result_code = err_q;
                    phase_d         = i2cras_pkg::PH_IDLE;
                    dev_d           = 8'd0;
                    reg_d           = 8'd0;
                    rlen_d          = 8'd0;
                    wlen_d          = 8'd0;
                    pos_d           = 8'd0;
                    err_d           = '0;
                    finished        = 1'b1;
                  end
                end
                i2cras_pkg::PH_DEVADDR: begin
                  if (sr1[i2cras_pkg::S1_TXE_BIT]) begin
                    res.data_write_valid = 1'b1;
                    res.data_write_value = reg_q;
                    if ((wlen_q == 8'd0) && (rlen_q != 8'd0)) begin
                      res.request_start = 1'b1;
                      phase_d           = i2cras_pkg::PH_RESTART;
                    end else begin
                      phase_d = i2cras_pkg::PH_WRITE;
                    end
                  end
                end
                i2cras_pkg::PH_RESTART: begin
                  if (sr1[i2cras_pkg::S1_SB_BIT]) begin
                    if (rlen_q == 8'd1) begin
                      res.ack_control = i2cras_pkg::ACK_DISABLE;
                    end
                    res.data_write_valid = 1'b1;
                    res.data_write_value = {dev_q[7:1], 1'b1};
                    phase_d              = i2cras_pkg::PH_READ;
                  end
                end
                i2cras_pkg::PH_READ: begin
                  if (sr1[i2cras_pkg::S1_RXNE_BIT]) begin
                    if (({1'b0, pos_q} + 9'd2) >= {1'b0, rlen_q}) begin
                      res.ack_control = i2cras_pkg::ACK_DISABLE;
                    end
                    res.data_read  = i2cras_pkg::DREAD_STORE;
                    res.read_index = pos_q;
                    pos_d          = pos_q + 8'd1;
                    if (pos_d >= rlen_q) begin
                      res.request_stop = 1'b1;
                      phase_d          = i2cras_pkg::PH_STOP;
                    end
                  end
                end
                i2cras_pkg::PH_WRITE: begin
                  if (sr1[i2cras_pkg::S1_TXE_BIT]) begin
                    if (pos_q >= wlen_q) begin
                      res.request_stop = 1'b1;
                      phase_d          = i2cras_pkg::PH_STOP;
                    end else begin
                      res.data_write_valid = 1'b1;
                      res.data_write_value = pos_in_store ? store_rdata_i : 8'd0;
                      pos_d                = pos_q + 8'd1;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
            if (!finished && xfer_late) begin
              err_d    = {i2cras_pkg::CODE_TIMEOUT, sr1};
              phase_d  = i2cras_pkg::PH_ERROR;
              drain_d  = 2'd0;
              tstart_d = item_i.time_now;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2cras_pkg::PH_IDLE;
      dev_q    <= '0;
      reg_q    <= '0;
      rlen_q   <= '0;
      wlen_q   <= '0;
      pos_q    <= '0;
      err_q    <= '0;
      tstart_q <= '0;
      drain_q  <= '0;
      wait_q   <= '0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      rlen_q   <= rlen_d;
      wlen_q   <= wlen_d;
      pos_q    <= pos_d;
      err_q    <= err_d;
      tstart_q <= tstart_d;
      drain_q  <= drain_d;
      wait_q   <= wait_d;
    end
  end

  // store is read ahead, at the byte position of the next step
  assign store_req_o.we    = step_en_i && store_we;
  assign store_req_o.waddr = item_i.load_index[i2cras_pkg::STORE_AW-1:0];
  assign store_req_o.wdata = item_i.load_value;
  assign store_req_o.raddr = step_en_i ? pos_d[i2cras_pkg::STORE_AW-1:0]
                                       : pos_q[i2cras_pkg::STORE_AW-1:0];
  assign result_o = res;

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.done_res |=> phase_q == i2cras_pkg::PH_IDLE)
    else $error("done without return to idle");

  a_reset_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.bus_reset |=>
      (phase_q == i2cras_pkg::PH_ERROR) && err_q[i2cras_pkg::ERR_RESET_BIT])
    else $error("bus reset without reset flag in error word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(phase_q) && $stable(pos_q) && $stable(err_q))
    else $error("state moved without a step");

  a_write_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.data_write_valid && (phase_q == i2cras_pkg::PH_WRITE) |=>
      pos_q == 8'($past(pos_q) + 8'd1))
    else $error("write byte sent without advancing position");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C register access sequencer - testbench
// Drives commands and controller status polls through the input channel and
// compares every result transaction with an in-bench prediction of the
// sequencer. Directed cases come first, then phases of random items that
// mostly play a cooperative controller, under changing timeouts and idling.
// ============================================================================
module tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 6;

  localparam logic [15:0] SB_F      = 16'd1 << i2cras_pkg::S1_SB_BIT;
  localparam logic [15:0] BTF_F     = 16'd1 << i2cras_pkg::S1_BTF_BIT;
  localparam logic [15:0] STOPF_F   = 16'd1 << i2cras_pkg::S1_STOPF_BIT;
  localparam logic [15:0] RXNE_F    = 16'd1 << i2cras_pkg::S1_RXNE_BIT;
  localparam logic [15:0] TXE_F     = 16'd1 << i2cras_pkg::S1_TXE_BIT;
  localparam logic [15:0] QUIET_S1  = 16'hA02A;
  localparam logic [15:0] BUS_HELD  = (16'd1 << i2cras_pkg::S2_BUSY_BIT) |
                                      (16'd1 << i2cras_pkg::S2_MSL_BIT);
  localparam logic [15:0] CR_ACK_F  = 16'd1 << i2cras_pkg::C_ACK_BIT;
  localparam logic [15:0] CR_STOP_F = 16'd1 << i2cras_pkg::C_STOP_BIT;

  typedef enum logic [2:0] {
    SQ_IDLE      = 3'd0,
    SQ_DEVADDR   = 3'd1,
    SQ_RESTART   = 3'd2,
    SQ_READ      = 3'd3,
    SQ_WRITE     = 3'd4,
    SQ_STOP      = 3'd5,
    SQ_ERROR     = 3'd6,
    SQ_STARTWAIT = 3'd7
  } seq_phase_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  i2cras_pkg::in_t   in_data_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_index_i = '0;
  logic [15:0]       cfg_wdata_i = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  i2cras_pkg::out_t  out_data_o;

  i2c_register_access_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // sequencer shadow state
  seq_phase_e  sq_phase    = SQ_IDLE;
  logic [7:0]  tgt_dev     = '0;
  logic [7:0]  tgt_reg     = '0;
  logic [7:0]  rd_len      = '0;
  logic [7:0]  wr_len      = '0;
  logic [7:0]  byte_pos    = '0;
  logic [24:0] err_word    = '0;
  logic [31:0] phase_t0    = '0;
  logic [1:0]  drain_left  = '0;
  logic [9:0]  sb_wait     = '0;
  logic [15:0] xfer_limit  = 16'd20;
  logic [15:0] recov_limit = 16'd10;
  logic [7:0]  wr_store [i2cras_pkg::STORE_DEPTH];
  bit          loaded   [i2cras_pkg::STORE_DEPTH];

  i2cras_pkg::out_t expected_q [$];
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_len     = 0;
  int          hold_serial  = 0;
  int          hold_served  = 0;
  int          hold_left    = 0;
  int          fill_goal    = 0;
  logic [31:0] tick_now     = '0;

  function automatic void clear_ctx();
    tgt_dev  = '0;
    tgt_reg  = '0;
    rd_len   = '0;
    wr_len   = '0;
    byte_pos = '0;
    err_word = '0;
  endfunction

  function automatic void enter_recovery(logic [24:0] code, logic [31:0] now);
    err_word   = code;
    sq_phase   = SQ_ERROR;
    drain_left = '0;
    phase_t0   = now;
  endfunction

  function automatic i2cras_pkg::out_t predict_result(i2cras_pkg::in_t it);
    i2cras_pkg::out_t r;
    logic        busy;
    logic        master;
    logic        ended;
    logic [31:0] elapsed;
    r       = '0;
    busy    = it.status_two[i2cras_pkg::S2_BUSY_BIT];
    master  = it.status_two[i2cras_pkg::S2_MSL_BIT];
    elapsed = it.time_now - phase_t0;
    ended   = 1'b0;
    if (it.command == i2cras_pkg::CMD_LOAD) begin
      wr_store[it.load_index] = it.load_value;
      loaded[it.load_index]   = 1'b1;
    end else if (it.command == i2cras_pkg::CMD_READ ||
                 it.command == i2cras_pkg::CMD_WRITE) begin
      if (sq_phase == SQ_IDLE) begin
        clear_ctx();
        tgt_dev = it.target_address;
        tgt_reg = it.register_address;
        if (it.command == i2cras_pkg::CMD_READ) rd_len = it.byte_count;
        else wr_len = it.byte_count;
        if (busy) begin
          enter_recovery({i2cras_pkg::CODE_BUSY, 16'h0} | 25'(it.status_one), it.time_now);
        end else begin
          r.status_clear  = i2cras_pkg::SCLR_ERRORS;
          r.ack_control   = i2cras_pkg::ACK_ENABLE;
          r.request_start = 1'b1;
          sb_wait         = '0;
          sq_phase        = SQ_STARTWAIT;
        end
      end
    end else if (sq_phase == SQ_STARTWAIT) begin
      if (it.status_one[i2cras_pkg::S1_SB_BIT]) begin
        r.data_write_valid = 1'b1;
        r.data_write_value = {tgt_dev[7:1], 1'b0};
        phase_t0           = it.time_now;
        sq_phase           = SQ_DEVADDR;
      end else begin
        sb_wait = sb_wait + 10'd1;
        if (sb_wait >= i2cras_pkg::START_WAIT_LIMIT_W)
          enter_recovery({i2cras_pkg::CODE_NO_START, 16'h0} | 25'(it.status_one),
                         it.time_now);
      end
    end else if (sq_phase == SQ_ERROR) begin
      if (elapsed > {16'h0, recov_limit}) begin
        err_word[i2cras_pkg::ERR_RESET_BIT] = 1'b1;
        r.bus_reset = 1'b1;
        phase_t0    = it.time_now;
      end else if (it.control_now[i2cras_pkg::C_ACK_BIT]) begin
        r.ack_control = i2cras_pkg::ACK_DISABLE;
        drain_left    = it.status_one[i2cras_pkg::S1_BTF_BIT] ? 2'd2 : 2'd1;
      end else if (busy && master && !it.status_one[i2cras_pkg::S1_STOPF_BIT] &&
                   !it.control_now[i2cras_pkg::C_STOP_BIT] && drain_left == 2'd0) begin
        r.request_stop = 1'b1;
      end else if (it.status_one[i2cras_pkg::S1_RXNE_BIT]) begin
        r.data_read = i2cras_pkg::DREAD_DISCARD;
        if (drain_left > 2'd0) drain_left = drain_left - 2'd1;
      end else if (!busy) begin
        r.status_clear = i2cras_pkg::SCLR_ALL;
        r.done_res     = 1'b1;
        r.result_code  = err_word;
        sq_phase       = SQ_IDLE;
        clear_ctx();
      end
    end else if (sq_phase != SQ_IDLE) begin
      if (sq_phase != SQ_STOP && (it.status_one & i2cras_pkg::S1_ERRORS) != 16'h0) begin
        err_word       = {6'd0, sq_phase, it.status_one & i2cras_pkg::S1_ERRORS};
        r.status_clear = i2cras_pkg::SCLR_ALL;
        if (!it.status_one[i2cras_pkg::S1_ARLO_BIT] && busy && master)
          r.request_stop = 1'b1;
        sq_phase = SQ_STOP;
        ended    = 1'b1;
      end else begin
        case (sq_phase)
          SQ_STOP: begin
            if (!busy) begin
              r.done_res    = 1'b1;
              r.result_code = err_word;
              sq_phase      = SQ_IDLE;
              clear_ctx();
              ended         = 1'b1;
            end
          end
          SQ_DEVADDR: begin
            if (it.status_one[i2cras_pkg::S1_TXE_BIT]) begin
              r.data_write_valid = 1'b1;
              r.data_write_value = tgt_reg;
              if (wr_len == 8'd0 && rd_len > 8'd0) begin
                r.request_start = 1'b1;
                sq_phase        = SQ_RESTART;
              end else begin
                sq_phase = SQ_WRITE;
              end
            end
          end
          SQ_RESTART: begin
            if (it.status_one[i2cras_pkg::S1_SB_BIT]) begin
              if (rd_len == 8'd1) r.ack_control = i2cras_pkg::ACK_DISABLE;
              r.data_write_valid = 1'b1;
              r.data_write_value = tgt_dev | 8'd1;
              sq_phase           = SQ_READ;
            end
          end
          SQ_READ: begin
            if (it.status_one[i2cras_pkg::S1_RXNE_BIT]) begin
              if (9'(byte_pos) + 9'd2 >= 9'(rd_len)) r.ack_control = i2cras_pkg::ACK_DISABLE;
              r.data_read  = i2cras_pkg::DREAD_STORE;
              r.read_index = byte_pos;
              byte_pos     = byte_pos + 8'd1;
              if (byte_pos >= rd_len) begin
                r.request_stop = 1'b1;
                sq_phase       = SQ_STOP;
              end
            end
          end
          SQ_WRITE: begin
            if (it.status_one[i2cras_pkg::S1_TXE_BIT]) begin
              if (byte_pos >= wr_len) begin
                r.request_stop = 1'b1;
                sq_phase       = SQ_STOP;
              end else begin
                r.data_write_valid = 1'b1;
                r.data_write_value = wr_store[byte_pos];
                byte_pos           = byte_pos + 8'd1;
              end
            end
          end
          default: ;
        endcase
      end
      if (!ended && elapsed > {16'h0, xfer_limit})
        enter_recovery({i2cras_pkg::CODE_TIMEOUT, 16'h0} | 25'(it.status_one), it.time_now);
    end
    return r;
  endfunction

  function automatic i2cras_pkg::in_t random_fill();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(i2cras_pkg::in_t)-1:0];
  endfunction

  function automatic logic [31:0] advance_clock();
    int r;
    r = $urandom_range(0, 999);
    if (r < 700) ;
    else if (r < 975) tick_now = tick_now + 32'd1;
    else if (r < 995) tick_now = tick_now + 32'($urandom_range(2, 40));
    else tick_now = tick_now + $urandom;
    return tick_now;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < i2cras_pkg::STORE_DEPTH && loaded[n]) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(0, 6));
    if (r < 92) return 8'($urandom_range(7, 40));
    if (r < 95) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly a well-behaved controller, with some noise and injected errors
  function automatic i2cras_pkg::in_t next_random_item();
    i2cras_pkg::in_t it;
    int  r;
    int  cap;
    it          = random_fill();
    it.time_now = advance_clock();
    if (sq_phase == SQ_IDLE) begin
      r   = $urandom_range(0, 99);
      cap = loaded_prefix();
      if (cap < fill_goal) begin
        it.command    = i2cras_pkg::CMD_LOAD;
        it.load_index = 8'(cap);
      end else if (r < 12) begin
        it.command = i2cras_pkg::CMD_LOAD;
      end else if (r < 22) begin
        it.command = i2cras_pkg::CMD_POLL;
      end else begin
        it.command    = ($urandom_range(0, 1) == 0) ? i2cras_pkg::CMD_READ
                                                    : i2cras_pkg::CMD_WRITE;
        it.byte_count = pick_length();
        it.status_two[i2cras_pkg::S2_BUSY_BIT] = ($urandom_range(0, 24) == 0);
        if (it.command == i2cras_pkg::CMD_WRITE && int'(it.byte_count) > cap) begin
          fill_goal     = int'(it.byte_count);
          it.command    = i2cras_pkg::CMD_LOAD;
          it.load_index = 8'(cap);
        end
      end
    end else if ($urandom_range(0, 99) >= 5) begin
      it.command     = i2cras_pkg::CMD_POLL;
      it.status_one  = 16'($urandom) & QUIET_S1;
      if ($urandom_range(0, 59) == 0) it.status_one |= 16'($urandom) & i2cras_pkg::S1_ERRORS;
      it.status_two  = (16'($urandom) & ~BUS_HELD) | BUS_HELD;
      it.control_now = 16'($urandom) & ~(CR_ACK_F | CR_STOP_F);
      case (sq_phase)
        SQ_STARTWAIT: if ($urandom_range(0, 9) < 6) it.status_one |= SB_F;
        SQ_DEVADDR, SQ_WRITE: if ($urandom_range(0, 9) < 8) it.status_one |= TXE_F;
        SQ_RESTART: if ($urandom_range(0, 9) < 8) it.status_one |= SB_F;
        SQ_READ: begin
          if ($urandom_range(0, 9) < 8) it.status_one |= RXNE_F;
          if ($urandom_range(0, 1) == 0) it.status_one |= BTF_F;
        end
        SQ_STOP: if ($urandom_range(0, 9) < 5) it.status_two[i2cras_pkg::S2_BUSY_BIT] = 1'b0;
        SQ_ERROR: begin
          if ($urandom_range(0, 9) < 2) it.control_now |= CR_ACK_F;
          if ($urandom_range(0, 9) < 2) it.control_now |= CR_STOP_F;
          if ($urandom_range(0, 1) == 0) it.status_one |= BTF_F;
          if ($urandom_range(0, 4) == 0) it.status_one |= STOPF_F;
          if ($urandom_range(0, 9) < 4) it.status_one |= RXNE_F;
          if ($urandom_range(0, 9) < 3) it.status_two[i2cras_pkg::S2_BUSY_BIT] = 1'b0;
          it.status_two[i2cras_pkg::S2_MSL_BIT] = ($urandom_range(0, 3) != 0);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input i2cras_pkg::in_t it);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_result(it));
  endtask

  task automatic send_poll(logic [15:0] s1, logic [15:0] s2, logic [15:0] cr);
    i2cras_pkg::in_t it;
    it             = random_fill();
    it.command     = i2cras_pkg::CMD_POLL;
    it.status_one  = s1;
    it.status_two  = s2;
    it.control_now = cr;
    it.time_now    = tick_now;
    send_item(it);
  endtask

  task automatic send_start(logic [1:0] cmd, logic [7:0] dev, logic [7:0] reg_addr,
                            logic [7:0] count, logic [15:0] s2);
    i2cras_pkg::in_t it;
    it                  = random_fill();
    it.command          = cmd;
    it.target_address   = dev;
    it.register_address = reg_addr;
    it.byte_count       = count;
    it.status_two       = s2;
    it.time_now         = tick_now;
    send_item(it);
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    i2cras_pkg::in_t it;
    it            = random_fill();
    it.command    = i2cras_pkg::CMD_LOAD;
    it.load_index = idx;
    it.load_value = val;
    it.time_now   = tick_now;
    send_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // also hits a spare index, which must leave both timeouts alone
  task automatic set_timeouts(logic [15:0] xfer, logic [15:0] recov);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= i2cras_pkg::CFG_TRANSFER_TIMEOUT;
    cfg_wdata_i <= xfer;
    @(posedge clk_i);
    cfg_index_i <= i2cras_pkg::CFG_RECOVERY_TIMEOUT;
    cfg_wdata_i <= recov;
    @(posedge clk_i);
    cfg_index_i <= i2cras_pkg::CFG_RECOVERY_TIMEOUT + 2'($urandom_range(1, 2));
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    xfer_limit  = xfer;
    recov_limit = recov;
  endtask

  task automatic test_store_loads();
    send_load(8'h00, 8'hFF);
    send_load(8'hFF, 8'h00);
    send_load(8'h01, 8'h5A);
  endtask

  task automatic test_busy_at_start();
    send_start(i2cras_pkg::CMD_WRITE, 8'hA5, 8'h3C, 8'd5, BUS_HELD);
    send_poll(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_single_byte_read();
    send_start(i2cras_pkg::CMD_READ, 8'hFF, 8'h00, 8'd1, 16'h0000);
    send_poll(SB_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(SB_F, BUS_HELD, 16'h0000);
    send_poll(RXNE_F, BUS_HELD, 16'h0000);
    send_poll(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_two_byte_write();
    send_start(i2cras_pkg::CMD_WRITE, 8'h00, 8'hFF, 8'd2, 16'h0000);
    send_poll(SB_F, BUS_HELD, 16'h0000);
    send_start(i2cras_pkg::CMD_READ, 8'h12, 8'h34, 8'd9, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_zero_length_read();
    send_start(i2cras_pkg::CMD_READ, 8'h55, 8'hAA, 8'd0, 16'h0000);
    send_poll(SB_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(TXE_F, BUS_HELD, 16'h0000);
    send_poll(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_start_wait_limit();
    send_start(i2cras_pkg::CMD_READ, 8'($urandom), 8'($urandom), 8'd3, 16'h0000);
    repeat (i2cras_pkg::START_WAIT_LIMIT)
      send_poll(16'($urandom) & ~SB_F, 16'($urandom), 16'($urandom));
    send_poll(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(next_random_item());
  endtask

  task automatic test_output_stall();
    settle();
    @(negedge clk_i);
    hold_len    = 300;
    hold_serial = hold_serial + 1;
    @(posedge clk_i);
    repeat (60) send_item(next_random_item());
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_serial) begin
      hold_served = hold_serial;
      hold_left   = hold_len;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    i2cras_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with none outstanding");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        cmp_field("data_write_valid", 32'(want.data_write_valid),
                  32'(out_data_o.data_write_valid));
        cmp_field("data_write_value", 32'(want.data_write_value),
                  32'(out_data_o.data_write_value));
        cmp_field("request_start", 32'(want.request_start),
                  32'(out_data_o.request_start));
        cmp_field("request_stop", 32'(want.request_stop),
                  32'(out_data_o.request_stop));
        cmp_field("ack_control", 32'(want.ack_control),
                  32'(out_data_o.ack_control));
        cmp_field("status_clear", 32'(want.status_clear),
                  32'(out_data_o.status_clear));
        cmp_field("bus_reset", 32'(want.bus_reset),
                  32'(out_data_o.bus_reset));
        cmp_field("data_read", 32'(want.data_read),
                  32'(out_data_o.data_read));
        cmp_field("read_index", 32'(want.read_index),
                  32'(out_data_o.read_index));
        cmp_field("done_res", 32'(want.done_res),
                  32'(out_data_o.done_res));
        cmp_field("result_code", 32'(want.result_code),
                  32'(out_data_o.result_code));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL i2c_register_access_sequencer");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle_pct = 29;
    rcv_idle_pct = 62;
    set_timeouts(16'd500, 16'd300);
    test_store_loads();
    test_busy_at_start();
    test_single_byte_read();
    test_two_byte_write();
    test_zero_length_read();
    test_start_wait_limit();

    settle();
    set_timeouts(16'($urandom_range(8, 60)), 16'($urandom_range(3, 30)));
    test_random(300);

    settle();
    snd_idle_pct = 62;
    rcv_idle_pct = 29;
    set_timeouts(16'hFFFF, 16'hFFFF);
    test_random(300);

    settle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_timeouts(16'd1, 16'd1);
    test_random(150);

    settle();
    set_timeouts(16'd20, 16'd10);
    test_random(100);

    test_output_stall();

    settle();
    if (fail_count == 0) $display("PASS i2c_register_access_sequencer");
    else $display("FAIL i2c_register_access_sequencer");
    $finish;
  end

endmodule

// ===== i2c_register_access_sequencer.f =====
rtl/i2cras_pkg.sv
rtl/i2cras_store.sv
rtl/i2cras_core.sv
rtl/i2c_register_access_sequencer.sv
tb/tb.sv
